>>> src/aed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aed_pkg;

    // Field widths
    localparam int unsigned BUF_SIZE_W  = 14;
    localparam int unsigned IDLE_W      = 16;
    localparam int unsigned DEADLINE_W  = 20;
    localparam int unsigned CFG_DATA_W  = 20;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned LEN_W       = 13;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CODE_W      = 2;
    // Overflow compare width: body count plus two, or the buffer size
    localparam int unsigned CMP_W       = BUF_SIZE_W + 1;
    // Largest buffer size the 14-bit register can name
    localparam int unsigned BUF_SIZE_TOP = 16383;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BUF_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADLINE = 2'd2;

    // Register reset values
    localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RST = 14'd8192;
    localparam logic [IDLE_W-1:0]     IDLE_RST     = 16'd3000;
    localparam logic [DEADLINE_W-1:0] DEADLINE_RST = 20'd5000;

    // Request codes
    localparam logic [CODE_W-1:0] REQ_START = 2'd0;
    localparam logic [CODE_W-1:0] REQ_BYTE  = 2'd1;
    localparam logic [CODE_W-1:0] REQ_TICK  = 2'd2;
    localparam logic [CODE_W-1:0] REQ_ABORT = 2'd3;

    // Result kinds
    localparam logic [CODE_W-1:0] KIND_BYTE = 2'd0;
    localparam logic [CODE_W-1:0] KIND_DONE = 2'd1;
    localparam logic [CODE_W-1:0] KIND_FAIL = 2'd2;

    // Failure causes
    localparam logic [CODE_W-1:0] CAUSE_IDLE     = 2'd0;
    localparam logic [CODE_W-1:0] CAUSE_DEADLINE = 2'd1;
    localparam logic [CODE_W-1:0] CAUSE_OVERFLOW = 2'd2;
    localparam logic [CODE_W-1:0] CAUSE_ABORT    = 2'd3;

    // Framing characters
    localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_INTRO = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_TERM  = 8'h5C;

    typedef struct packed {
        logic [BUF_SIZE_W-1:0] buf_size;
        logic [IDLE_W-1:0]     idle_limit;
        logic [DEADLINE_W-1:0] deadline_limit;
    } aed_cfg_t;

    // One queued command; pair means ESC goes out ahead of data_byte
    typedef struct packed {
        logic [CODE_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  body_length;
        logic [CODE_W-1:0] fail_cause;
        logic              pair;
    } aed_cmd_t;

endpackage

`default_nettype wire

>>> src/aed_front.sv
`timescale 1ns / 1ps
`default_nettype none

module aed_front
    import aed_pkg::*;
#(
    parameter int unsigned BUF_MAX = 8192
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [CODE_W-1:0] req_type,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire aed_cfg_t          cfg,
    output logic                   push,
    output aed_cmd_t               cmd
);

    localparam int unsigned SIZE_CAP = (BUF_MAX > BUF_SIZE_TOP) ? BUF_SIZE_TOP : BUF_MAX;
    localparam int unsigned CNT_W    = $clog2(SIZE_CAP);

    // Frame scan phases
    localparam logic [1:0] PH_SCAN  = 2'd0;
    localparam logic [1:0] PH_INTRO = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;
    localparam logic [1:0] PH_ESC   = 2'd3;

    logic                  active_reg, active_next;
    logic [1:0]            phase_reg, phase_next;
    logic [CNT_W-1:0]      body_count_reg, body_count_next;
    logic [IDLE_W-1:0]     idle_ticks_reg, idle_ticks_next;
    logic [DEADLINE_W-1:0] elapsed_ticks_reg, elapsed_ticks_next;

    logic [BUF_SIZE_W-1:0] eff_size;
    logic [CMP_W-1:0]      size_ext;
    logic [CMP_W-1:0]      count_plus1;
    logic [CMP_W-1:0]      count_plus2;

    // Buffer size clamped to the build limit
    assign eff_size    = (cfg.buf_size > BUF_SIZE_W'(SIZE_CAP)) ?
                         BUF_SIZE_W'(SIZE_CAP) : cfg.buf_size;
    assign size_ext    = CMP_W'(eff_size);
    assign count_plus1 = CMP_W'(body_count_reg) + CMP_W'(1);
    assign count_plus2 = CMP_W'(body_count_reg) + CMP_W'(2);

    // Classify the item, update the receive state, emit a command
    always_comb
    begin
        active_next        = active_reg;
        phase_next         = phase_reg;
        body_count_next    = body_count_reg;
        idle_ticks_next    = idle_ticks_reg;
        elapsed_ticks_next = elapsed_ticks_reg;
        push               = 1'b0;
        cmd                = '0;
        if (accept)
        begin
            unique case (req_type)
                REQ_START:
                begin
                    active_next        = 1'b1;
                    phase_next         = PH_SCAN;
                    body_count_next    = '0;
                    idle_ticks_next    = '0;
                    elapsed_ticks_next = '0;
                end
                REQ_ABORT:
                begin
                    if (active_reg)
                    begin
                        active_next    = 1'b0;
                        push           = 1'b1;
                        cmd.kind       = KIND_FAIL;
                        cmd.fail_cause = CAUSE_ABORT;
                    end
                end
                REQ_TICK:
                begin
                    if (active_reg)
                    begin
                        // deadline wins over idle gap
                        if (elapsed_ticks_reg >= cfg.deadline_limit)
                        begin
                            active_next    = 1'b0;
                            push           = 1'b1;
                            cmd.kind       = KIND_FAIL;
                            cmd.fail_cause = CAUSE_DEADLINE;
                        end
                        else if (idle_ticks_reg >= cfg.idle_limit)
                        begin
                            active_next    = 1'b0;
                            push           = 1'b1;
                            cmd.kind       = KIND_FAIL;
                            cmd.fail_cause = CAUSE_IDLE;
                        end
                        else
                        begin
                            elapsed_ticks_next = elapsed_ticks_reg + DEADLINE_W'(1);
                            idle_ticks_next    = idle_ticks_reg + IDLE_W'(1);
                        end
                    end
                end
                REQ_BYTE:
                begin
                    if (active_reg)
                    begin
                        idle_ticks_next = '0;
                        unique case (phase_reg)
                            PH_SCAN:
                            begin
                                if (rx_byte == CH_ESC)
                                    phase_next = PH_INTRO;
                            end
                            PH_INTRO:
                            begin
                                phase_next = (rx_byte == CH_INTRO) ? PH_BODY : PH_SCAN;
                            end
                            PH_BODY:
                            begin
                                if (rx_byte == CH_ESC)
                                    phase_next = PH_ESC;
                                else if (count_plus1 >= size_ext)
                                begin
                                    active_next    = 1'b0;
                                    push           = 1'b1;
                                    cmd.kind       = KIND_FAIL;
                                    cmd.fail_cause = CAUSE_OVERFLOW;
                                end
                                else
                                begin
                                    body_count_next = body_count_reg + CNT_W'(1);
                                    push            = 1'b1;
                                    cmd.kind        = KIND_BYTE;
                                    cmd.data_byte   = rx_byte;
                                end
                            end
                            PH_ESC:
                            begin
                                if (rx_byte == CH_TERM)
                                begin
                                    active_next     = 1'b0;
                                    push            = 1'b1;
                                    cmd.kind        = KIND_DONE;
                                    cmd.body_length = LEN_W'(body_count_reg);
                                end
                                else if (count_plus2 >= size_ext)
                                begin
                                    active_next    = 1'b0;
                                    push           = 1'b1;
                                    cmd.kind       = KIND_FAIL;
                                    cmd.fail_cause = CAUSE_OVERFLOW;
                                end
                                else
                                begin
                                    // stray ESC kept: ESC and this byte go out
                                    body_count_next = body_count_reg + CNT_W'(2);
                                    phase_next      = PH_BODY;
                                    push            = 1'b1;
                                    cmd.kind        = KIND_BYTE;
                                    cmd.data_byte   = rx_byte;
                                    cmd.pair        = 1'b1;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_SCAN;
                            end
                        endcase
                    end
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    // Receive state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg        <= 1'b0;
            phase_reg         <= PH_SCAN;
            body_count_reg    <= '0;
            idle_ticks_reg    <= '0;
            elapsed_ticks_reg <= '0;
        end
        else
        begin
            active_reg        <= active_next;
            phase_reg         <= phase_next;
            body_count_reg    <= body_count_next;
            idle_ticks_reg    <= idle_ticks_next;
            elapsed_ticks_reg <= elapsed_ticks_next;
        end
    end

endmodule

`default_nettype wire

>>> src/aed_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module aed_cmd_fifo
    import aed_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire aed_cmd_t push_cmd,
    input  wire logic     pop,
    output aed_cmd_t      head_cmd,
    output logic          full,
    output logic          empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    aed_cmd_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

>>> src/aed_back.sv
`timescale 1ns / 1ps
`default_nettype none

module aed_back
    import aed_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire aed_cmd_t    head_cmd,
    input  wire logic        empty,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic [CODE_W-1:0] m_tuser,
    output logic             m_tlast
);

    logic                out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]   out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic [LEN_W-1:0]    out_len_reg, out_len_next;
    logic [CODE_W-1:0]   out_cause_reg, out_cause_next;
    logic                out_last_reg, out_last_next;
    logic                pend_reg, pend_next;
    logic [BYTE_W-1:0]   pend_byte_reg, pend_byte_next;
    logic                load;

    // Output register may be refilled when empty or being taken
    assign load = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_len_next   = out_len_reg;
        out_cause_next = out_cause_reg;
        out_last_next  = out_last_reg;
        pend_next      = pend_reg;
        pend_byte_next = pend_byte_reg;
        pop            = 1'b0;
        if (load)
        begin
            priority if (pend_reg)
            begin
                // second half of an ESC pair
                out_valid_next = 1'b1;
                out_kind_next  = KIND_BYTE;
                out_byte_next  = pend_byte_reg;
                out_len_next   = '0;
                out_cause_next = '0;
                out_last_next  = 1'b1;
                pend_next      = 1'b0;
            end
            else if (!empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                out_kind_next  = head_cmd.kind;
                out_len_next   = head_cmd.body_length;
                out_cause_next = head_cmd.fail_cause;
                if (head_cmd.pair)
                begin
                    out_byte_next  = CH_ESC;
                    out_last_next  = 1'b0;
                    pend_next      = 1'b1;
                    pend_byte_next = head_cmd.data_byte;
                end
                else
                begin
                    out_byte_next = head_cmd.data_byte;
                    out_last_next = 1'b1;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_len_reg   <= out_len_next;
        out_cause_reg <= out_cause_next;
        out_last_reg  <= out_last_next;
        pend_byte_reg <= pend_byte_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_cause_reg, out_len_reg, out_byte_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> src/apc_escape_deframer_unit.sv
// Channel   Signals                                Moves
// s_        s_tvalid s_tready s_tdata s_tuser      one request per transfer
// m_        m_tvalid m_tready m_tdata m_tuser m_tlast  one result per transfer
// cfg_      cfg_we cfg_index cfg_wdata             register write, no wait
//
// One request is taken every cycle while the command queue has room.
// Results leave one per cycle while m_tready is high; an ESC pair takes
// two output transfers. The queue (QUEUE_DEPTH commands) and the output
// register let input and output stall independently.
// rst_n clears the receive state, queue and output; registers reload defaults.
`timescale 1ns / 1ps
`default_nettype none

module apc_escape_deframer_unit
    import aed_pkg::*;
#(
    parameter int unsigned BUF_MAX     = 8192,
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] rx_byte
    input  wire logic [CODE_W-1:0]      s_tuser,   // [1:0] req_type
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [23:0]                 m_tdata,   // [7:0] data_byte, [20:8] body_length,
                                                   // [22:21] fail_cause
    output logic [CODE_W-1:0]           m_tuser,   // [1:0] kind
    output logic                        m_tlast,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    aed_cfg_t cfg_reg;
    aed_cmd_t push_cmd;
    aed_cmd_t head_cmd;
    logic     accept;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.buf_size       <= BUF_SIZE_RST;
            cfg_reg.idle_limit     <= IDLE_RST;
            cfg_reg.deadline_limit <= DEADLINE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BUF_SIZE: cfg_reg.buf_size       <= cfg_wdata[BUF_SIZE_W-1:0];
                REG_IDLE:     cfg_reg.idle_limit     <= cfg_wdata[IDLE_W-1:0];
                REG_DEADLINE: cfg_reg.deadline_limit <= cfg_wdata[DEADLINE_W-1:0];
                default:      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    aed_front #(
        .BUF_MAX (BUF_MAX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (s_tuser),
        .rx_byte  (s_tdata),
        .cfg      (cfg_reg),
        .push     (push),
        .cmd      (push_cmd)
    );

    aed_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (full),
        .empty    (empty)
    );

    aed_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> src/aed_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module aed_checker
    import aed_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [23:0]       m_tdata,
    input wire logic [CODE_W-1:0] m_tuser,
    input wire logic              m_tlast
);

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only the first half of an ESC pair is not last, and it is an ESC byte
    a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser == KIND_BYTE && m_tdata[7:0] == CH_ESC)
        else $error("non-last result is not an ESC byte");

    // The second half of a pair follows at once and closes the item
    a_pair_tail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast && m_tuser == KIND_BYTE)
        else $error("ESC pair not followed by its byte");

    // Failure and completion carry no byte and end the item
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_FAIL || m_tuser == KIND_DONE)
        |-> m_tlast && m_tdata[7:0] == '0)
        else $error("status result malformed");

    // Kind stays within its codes
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser == KIND_BYTE || m_tuser == KIND_DONE || m_tuser == KIND_FAIL)
        else $error("unknown result kind");

endmodule

bind apc_escape_deframer_unit aed_checker u_aed_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> tb/apc_frame_check_pkg.sv
`timescale 1ns / 1ps

package apc_frame_check_pkg;

    import aed_pkg::*;

    // Buffer cap the block is built with; the size register is clamped to it
    localparam int unsigned FRAME_BUF_MAX = 8192;

    // Where the receiver is within a frame
    typedef enum logic [1:0] {
        SCAN_ESC,
        SCAN_INTRO,
        IN_BODY,
        BODY_ESC
    } scan_t;

    // One result as it leaves the block
    typedef struct packed {
        logic [CODE_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  body_length;
        logic [CODE_W-1:0] fail_cause;
        logic              last;
    } apc_result_t;

    class apc_frame_scoreboard;

        // Register copies
        logic [BUF_SIZE_W-1:0] buf_size;
        logic [IDLE_W-1:0]     idle_limit;
        logic [DEADLINE_W-1:0] deadline_limit;

        // Receive state
        bit          armed;
        scan_t       scan;
        int unsigned body_count;
        int unsigned idle_ticks;
        int unsigned elapsed_ticks;

        apc_result_t frame_q[$];

        int unsigned failures;
        int unsigned byte_results;
        int unsigned done_results;
        int unsigned fail_results;

        function new();
            buf_size       = BUF_SIZE_RST;
            idle_limit     = IDLE_RST;
            deadline_limit = DEADLINE_RST;
            armed          = 1'b0;
            scan           = SCAN_ESC;
            body_count     = 0;
            idle_ticks     = 0;
            elapsed_ticks  = 0;
            failures       = 0;
            byte_results   = 0;
            done_results   = 0;
            fail_results   = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_BUF_SIZE: buf_size = val[BUF_SIZE_W-1:0];
                REG_IDLE:     idle_limit = val[IDLE_W-1:0];
                REG_DEADLINE: deadline_limit = val[DEADLINE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return frame_q.size();
        endfunction

        function void push(logic [CODE_W-1:0] kind, logic [BYTE_W-1:0] data_byte,
                           int unsigned body_length, logic [CODE_W-1:0] fail_cause,
                           logic last);
            apc_result_t r;
            r.kind        = kind;
            r.data_byte   = data_byte;
            r.body_length = body_length[LEN_W-1:0];
            r.fail_cause  = fail_cause;
            r.last        = last;
            frame_q.push_back(r);
        endfunction

        // Any failure drops the receiver back to idle
        function void push_failure(logic [CODE_W-1:0] cause);
            armed = 1'b0;
            push(KIND_FAIL, '0, 0, cause, 1'b1);
        endfunction

        // Returns 1 when the request was acted on, 0 when the idle block ignores it
        function bit note_request(logic [CODE_W-1:0] req, logic [BYTE_W-1:0] ch);
            int unsigned room;
            if (req == REQ_START)
            begin
                armed         = 1'b1;
                scan          = SCAN_ESC;
                body_count    = 0;
                idle_ticks    = 0;
                elapsed_ticks = 0;
                return 1'b1;
            end
            if (!armed)
                return 1'b0;
            if (req == REQ_ABORT)
            begin
                push_failure(CAUSE_ABORT);
                return 1'b1;
            end
            // Deadline is checked ahead of the idle gap
            if (req == REQ_TICK)
            begin
                if (elapsed_ticks >= 32'(deadline_limit))
                    push_failure(CAUSE_DEADLINE);
                else if (idle_ticks >= 32'(idle_limit))
                    push_failure(CAUSE_IDLE);
                else
                begin
                    elapsed_ticks++;
                    idle_ticks++;
                end
                return 1'b1;
            end

            idle_ticks = 0;
            room = (32'(buf_size) > FRAME_BUF_MAX) ? FRAME_BUF_MAX : 32'(buf_size);
            case (scan)
                SCAN_ESC:
                begin
                    if (ch == CH_ESC)
                        scan = SCAN_INTRO;
                end
                SCAN_INTRO:
                    scan = (ch == CH_INTRO) ? IN_BODY : SCAN_ESC;
                IN_BODY:
                begin
                    if (ch == CH_ESC)
                        scan = BODY_ESC;
                    else if (body_count + 1 >= room)
                        push_failure(CAUSE_OVERFLOW);
                    else
                    begin
                        body_count++;
                        push(KIND_BYTE, ch, 0, '0, 1'b1);
                    end
                end
                default:
                begin
                    // ESC backslash closes the frame, anything else is a kept pair
                    if (ch == CH_TERM)
                    begin
                        armed = 1'b0;
                        push(KIND_DONE, '0, body_count, '0, 1'b1);
                    end
                    else if (body_count + 2 >= room)
                        push_failure(CAUSE_OVERFLOW);
                    else
                    begin
                        body_count += 2;
                        scan = IN_BODY;
                        push(KIND_BYTE, CH_ESC, 0, '0, 1'b0);
                        push(KIND_BYTE, ch, 0, '0, 1'b1);
                    end
                end
            endcase
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v)
            begin
                failures++;
                $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
            end
        endfunction

        function void check_result(apc_result_t got);
            apc_result_t want;
            if (frame_q.size() == 0)
            begin
                failures++;
                $error("unexpected result: kind %0h data_byte %0h body_length %0h",
                       got.kind, got.data_byte, got.body_length);
                return;
            end
            want = frame_q.pop_front();
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
            compare_field("body_length", 32'(want.body_length), 32'(got.body_length));
            compare_field("fail_cause", 32'(want.fail_cause), 32'(got.fail_cause));
            compare_field("last", 32'(want.last), 32'(got.last));
            case (want.kind)
                KIND_BYTE: byte_results++;
                KIND_DONE: done_results++;
                default:   fail_results++;
            endcase
        endfunction

    endclass

endpackage

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import aed_pkg::*;
    import apc_frame_check_pkg::*;

    localparam int unsigned TARGET_ITEMS  = 1950;
    localparam int unsigned PHASE_ITEMS   = 180;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned QUIET_LIMIT   = 4000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;    // [7:0] rx_byte
    logic [CODE_W-1:0]      s_tuser;    // [1:0] req_type
    logic                   m_tvalid;
    logic                   m_tready;
    logic [23:0]            m_tdata;    // [7:0] data_byte, [20:8] body_length,
                                        // [22:21] fail_cause
    logic [CODE_W-1:0]      m_tuser;    // [1:0] kind
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    apc_frame_scoreboard sb = new();

    int unsigned sent_items;
    int unsigned acted_items;
    int unsigned settings_used;
    int unsigned burst_left;
    int unsigned quiet_cycles;
    apc_result_t seen;

    apc_escape_deframer_unit #(
        .BUF_MAX (FRAME_BUF_MAX)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sender gaps: mostly none or short, a few long, with gap-free bursts
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_left != 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Any byte value
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Bytes biased towards the framing characters
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 15);
        case (r)
            0, 1:    return CH_ESC;
            2:       return CH_INTRO;
            3:       return CH_TERM;
            default: return rand_byte();
        endcase
    endfunction

    // One request transfer; the scoreboard sees it at the accepting edge
    task automatic send(input logic [CODE_W-1:0] req, input logic [7:0] ch);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= ch;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_items++;
        if (sb.note_request(req, ch))
            acted_items++;
    endtask

    // Hold the sender off until every result is out and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] size_v,
                                input logic [CFG_DATA_W-1:0] idle_v,
                                input logic [CFG_DATA_W-1:0] deadline_v);
        write_reg(REG_BUF_SIZE, size_v);
        write_reg(REG_IDLE, idle_v);
        write_reg(REG_DEADLINE, deadline_v);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Register settings per random phase: extremes first, then mostly small values
    task automatic choose_setting(input int unsigned idx,
                                  output logic [CFG_DATA_W-1:0] size_v,
                                  output logic [CFG_DATA_W-1:0] idle_v,
                                  output logic [CFG_DATA_W-1:0] deadline_v);
        case (idx)
            0:
            begin
                size_v = 1;
                idle_v = 1;
                deadline_v = 1;
            end
            1:
            begin
                size_v = 0;
                idle_v = 0;
                deadline_v = 0;
            end
            2:
            begin
                size_v = CFG_DATA_W'(BUF_SIZE_TOP);
                idle_v = 20'hFFFF;
                deadline_v = 20'hFFFFF;
            end
            3:
            begin
                size_v = CFG_DATA_W'(FRAME_BUF_MAX);
                idle_v = 3;
                deadline_v = 30;
            end
            default:
            begin
                size_v = CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
                                     $urandom_range(25, BUF_SIZE_TOP) :
                                     $urandom_range(2, 24));
                idle_v = CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
                                     $urandom_range(7, 65535) :
                                     $urandom_range(0, 6));
                deadline_v = CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
                                         $urandom_range(51, 1048575) :
                                         $urandom_range(0, 50));
            end
        endcase
    endtask

    // Mostly a well-formed frame with random content, now and then broken
    task automatic run_frame();
        int unsigned n_body;
        int unsigned r;
        send(REQ_START, rand_byte());
        repeat ($urandom_range(0, 3))
        begin
            if ($urandom_range(0, 3) == 0)
                send(REQ_TICK, rand_byte());
            else
                send(REQ_BYTE, pick_byte());
        end
        if (!sb.armed)
            return;
        // A doubled ESC spoils the introducer
        if ($urandom_range(0, 9) == 0)
            send(REQ_BYTE, CH_ESC);
        send(REQ_BYTE, CH_ESC);
        send(REQ_BYTE, CH_INTRO);
        n_body = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        for (int unsigned k = 0; k < n_body && sb.armed; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                repeat ($urandom_range(1, 8))
                    send(REQ_TICK, rand_byte());
            end
            else if (r < 18)
            begin
                send(REQ_BYTE, CH_ESC);
                send(REQ_BYTE, ($urandom_range(0, 7) == 0) ? pick_byte() : rand_byte());
            end
            else
                send(REQ_BYTE, rand_byte());
        end
        if (!sb.armed)
            return;
        r = $urandom_range(0, 19);
        case (r)
            0: send(REQ_ABORT, rand_byte());
            1: send(REQ_START, rand_byte());
            2: ;
            3:
            begin
                repeat ($urandom_range(1, 10))
                    send(REQ_TICK, rand_byte());
            end
            default:
            begin
                send(REQ_BYTE, CH_ESC);
                send(REQ_BYTE, CH_TERM);
            end
        endcase
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            send(CODE_W'($urandom_range(0, 3)), rand_byte());
    endtask

    // Result side: ready drops at random, with long stretches of no stalls
    initial
    begin
        int unsigned r;
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(30, 100)) @(posedge clk);
            end
            else if (r < 65)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else if (r < 94)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.kind        = m_tuser;
            seen.data_byte   = m_tdata[7:0];
            seen.body_length = m_tdata[20:8];
            seen.fail_cause  = m_tdata[22:21];
            seen.last        = m_tlast;
            sb.check_result(seen);
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] size_v;
        logic [CFG_DATA_W-1:0] idle_v;
        logic [CFG_DATA_W-1:0] deadline_v;
        int unsigned phase_idx;
        int unsigned next_phase_at;

        sent_items    = 0;
        acted_items   = 0;
        settings_used = 0;
        burst_left    = 0;
        quiet_cycles  = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_START;
        cfg_we    <= 1'b0;
        cfg_index <= REG_BUF_SIZE;
        cfg_wdata <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: requests to an idle block, spoilt introducer,
        // restart while armed, plain byte, kept ESC pair, normal end
        send(REQ_BYTE, 8'hFF);
        send(REQ_TICK, 8'h00);
        send(REQ_ABORT, 8'hFF);
        send(REQ_START, 8'h00);
        send(REQ_BYTE, CH_ESC);
        send(REQ_BYTE, CH_ESC);
        send(REQ_BYTE, CH_INTRO);
        send(REQ_START, 8'hFF);
        send(REQ_BYTE, CH_ESC);
        send(REQ_BYTE, CH_INTRO);
        send(REQ_BYTE, 8'h00);
        send(REQ_BYTE, CH_ESC);
        send(REQ_BYTE, 8'hFF);
        send(REQ_BYTE, CH_ESC);
        send(REQ_BYTE, CH_TERM);

        // Tight limits: idle timeout, deadline beating idle, overflow on a pair
        settle();
        program_regs(3, 1, 2);
        send(REQ_START, 8'h00);
        send(REQ_TICK, 8'h00);
        send(REQ_TICK, 8'h00);
        send(REQ_START, 8'h00);
        send(REQ_TICK, 8'h00);
        send(REQ_BYTE, CH_ESC);
        send(REQ_TICK, 8'h00);
        send(REQ_TICK, 8'h00);
        send(REQ_START, 8'h00);
        send(REQ_BYTE, CH_ESC);
        send(REQ_BYTE, CH_INTRO);
        send(REQ_BYTE, 8'h41);
        send(REQ_BYTE, CH_ESC);
        send(REQ_BYTE, 8'h42);

        // Random frames under a new register setting every phase
        phase_idx = 0;
        next_phase_at = acted_items;
        while (acted_items < TARGET_ITEMS)
        begin
            if (acted_items >= next_phase_at)
            begin
                settle();
                choose_setting(phase_idx, size_v, idle_v, deadline_v);
                program_regs(size_v, idle_v, deadline_v);
                phase_idx++;
                next_phase_at = acted_items + PHASE_ITEMS;
            end
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                run_frame();
        end

        settle();
        $display("Ran %0d request transfers (%0d acted on) over %0d register settings.",
                 sent_items, acted_items, settings_used);
        $display("Checked %0d body bytes, %0d completed frames and %0d failed receives.",
                 sb.byte_results, sb.done_results, sb.fail_results);
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
src/aed_pkg.sv
src/aed_front.sv
src/aed_cmd_fifo.sv
src/aed_back.sv
src/apc_escape_deframer_unit.sv
src/aed_checker.sv
tb/apc_frame_check_pkg.sv
tb/testbench.sv
